/* sv/ght_pkg.sv */
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// Handle layout, operation and status codes, sequencer states and the
// layout of one slot entry as it is held in the slot memory.
// ----------------------------------------------------------------------------
package ght_pkg;

	localparam int SLOT_COUNT_DEF = 256;
	localparam int HANDLE_W       = 64;
	localparam int IDX_W          = 32;
	localparam int TAG_W          = 32;

	localparam logic [HANDLE_W-1:0] NULL_HANDLE = '1;
	localparam logic [TAG_W-1:0]    TAG_LIMIT   = '1;

	typedef enum logic [1:0] {
		MODE_CREATE   = 2'd0,
		MODE_LOOKUP   = 2'd1,
		MODE_DESTROY  = 2'd2,
		MODE_REPARENT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_RANGE   = 3'd2,
		ST_STALE   = 3'd3,
		ST_DEAD    = 3'd4,
		ST_FULL    = 3'd5,
		ST_SELF    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_RESP
	} state_t;

	// slot index is implied by the address, so only the tag is kept
	typedef struct packed {
		logic                live;
		logic [TAG_W-1:0]    tag;
		logic [HANDLE_W-1:0] parent;
	} entry_t;

endpackage

/* sv/ght_req_if.sv */
// ----------------------------------------------------------------------------
// ght_req_if: request channel of the generational handle table
// Valid/ready channel carrying one table operation per transfer.
// ----------------------------------------------------------------------------
interface ght_req_if;
	logic                              valid;
	logic                              ready;
	ght_pkg::mode_t                    mode;
	logic [ght_pkg::HANDLE_W-1:0]      handle;
	logic [ght_pkg::HANDLE_W-1:0]      parent_handle;
	logic [ght_pkg::TAG_W-1:0]         new_tag;

	modport source (output valid, mode, handle, parent_handle, new_tag, input ready);
	modport sink   (input valid, mode, handle, parent_handle, new_tag, output ready);
endinterface

/* sv/ght_rsp_if.sv */
// ----------------------------------------------------------------------------
// ght_rsp_if: response channel of the generational handle table
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface ght_rsp_if;
	logic                              valid;
	logic                              ready;
	ght_pkg::status_t                  status;
	logic [ght_pkg::HANDLE_W-1:0]      handle_out;
	logic [ght_pkg::HANDLE_W-1:0]      parent_out;

	modport source (output valid, status, handle_out, parent_out, input ready);
	modport sink   (input valid, status, handle_out, parent_out, output ready);
endinterface

/* sv/generational_handle_table_unit.sv */
// ----------------------------------------------------------------------------
// generational_handle_table_unit: slot table addressed by generational handles
// Create, lookup, destroy and reparent on a table of SLOT_COUNT entries.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer (mode, handle, parent_handle,
//   new_tag); rsp returns exactly one result per request (status,
//   handle_out, parent_out). A handle holds the slot index in bits 31..0
//   and the generation tag in bits 63..32.
//   Lookup and reparent read the slot memory once, in S_CHECK, before the
//   result is offered. Requests rejected on the request alone (invalid
//   handle, index out of range, create with the reserved tag) skip the
//   read and go straight to S_RESP.
//   Create and destroy sweep the slots in use through the single memory
//   read port, one slot a cycle. Create stops at the first dead slot.
//   One request is in flight at a time; req.ready is high only between
//   operations. The result sits in an output register, so the next
//   request is taken while rsp is stalled; a further result then waits
//   until rsp is free.
//   Reset clears the slot count and the output valid; slot memory needs no
//   clearing since slots at or above the count are never read.
// ----------------------------------------------------------------------------
module generational_handle_table_unit #(
	parameter int SLOT_COUNT = ght_pkg::SLOT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ght_req_if.sink   req,
	ght_rsp_if.source rsp
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int UW = $clog2(SLOT_COUNT + 1);
	localparam int HW = ght_pkg::HANDLE_W;
	localparam int XW = ght_pkg::IDX_W;
	localparam int TW = ght_pkg::TAG_W;

	ght_pkg::state_t  state_q, state_d;
	ght_pkg::mode_t   op_q, op_d;
	logic [HW-1:0]    h_q, h_d;
	logic [HW-1:0]    p_q, p_d;
	logic [TW-1:0]    tag_q, tag_d;
	logic [HW-1:0]    up_q, up_d;
	logic [UW-1:0]    cnt_q, cnt_d;
	logic [UW-1:0]    used_q, used_d;
	logic             pend_q, pend_d;
	logic [IW-1:0]    pidx_q, pidx_d;

	ght_pkg::status_t rs_q, rs_d;
	logic [HW-1:0]    rh_q, rh_d;
	logic [HW-1:0]    rp_q, rp_d;

	logic             out_valid_q;
	ght_pkg::status_t out_status_q;
	logic [HW-1:0]    out_handle_q;
	logic [HW-1:0]    out_parent_q;
	logic             out_load;

	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	ght_pkg::entry_t  ram_wdata;
	logic [IW-1:0]    ram_raddr;
	ght_pkg::entry_t  ram_rdata;

	logic             issue;
	logic [XW-1:0]    pidx_ext;
	logic [XW-1:0]    used_ext;

	ght_ram #(
		.WIDTH ($bits(ght_pkg::entry_t)),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready      = (state_q == ght_pkg::S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.handle_out = out_handle_q;
	assign rsp.parent_out = out_parent_q;

	assign pidx_ext = {{(XW-IW){1'b0}}, pidx_q};
	assign used_ext = {{(XW-UW){1'b0}}, used_q};

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		h_d       = h_q;
		p_d       = p_q;
		tag_d     = tag_q;
		up_d      = up_q;
		cnt_d     = cnt_q;
		used_d    = used_q;
		pend_d    = 1'b0;
		pidx_d    = cnt_q[IW-1:0];
		rs_d      = rs_q;
		rh_d      = rh_q;
		rp_d      = rp_q;
		ram_we    = 1'b0;
		ram_waddr = pidx_q;
		ram_wdata = ram_rdata;
		ram_raddr = req.handle[IW-1:0];
		out_load  = 1'b0;
		issue     = 1'b0;
		case (state_q)
			ght_pkg::S_IDLE: begin
				if (req.valid) begin
					op_d  = req.mode;
					h_d   = req.handle;
					p_d   = req.parent_handle;
					tag_d = req.new_tag;
					cnt_d = '0;
					rs_d  = ght_pkg::ST_INVALID;
					rh_d  = ght_pkg::NULL_HANDLE;
					rp_d  = '0;
					if (req.mode == ght_pkg::MODE_CREATE) begin
						if (req.new_tag == ght_pkg::TAG_LIMIT) begin
							state_d = ght_pkg::S_RESP;
						end else begin
							state_d = ght_pkg::S_SCAN;
						end
					end else if (req.handle == ght_pkg::NULL_HANDLE) begin
						state_d = ght_pkg::S_RESP;
					end else if (req.handle[XW-1:0] >= used_ext) begin
						rs_d    = ght_pkg::ST_RANGE;
						state_d = ght_pkg::S_RESP;
					end else begin
						state_d = ght_pkg::S_CHECK;
					end
				end
			end
			ght_pkg::S_CHECK: begin
				ram_waddr = h_q[IW-1:0];
				state_d   = ght_pkg::S_RESP;
				if (ram_rdata.tag != h_q[HW-1:XW]) begin
					rs_d = ght_pkg::ST_STALE;
				end else if (!ram_rdata.live) begin
					rs_d = ght_pkg::ST_DEAD;
				end else begin
					rs_d = ght_pkg::ST_OK;
					rh_d = h_q;
					rp_d = ram_rdata.parent;
					case (op_q)
						ght_pkg::MODE_REPARENT: begin
							if (p_q == h_q) begin
								rs_d = ght_pkg::ST_SELF;
							end else begin
								ram_we           = 1'b1;
								ram_wdata.parent = p_q;
								rp_d             = p_q;
							end
						end
						ght_pkg::MODE_DESTROY: begin
							ram_we         = 1'b1;
							ram_wdata.live = 1'b0;
							up_d           = ram_rdata.parent;
							state_d        = ght_pkg::S_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			ght_pkg::S_SCAN: begin
				issue     = (cnt_q < used_q);
				ram_raddr = cnt_q[IW-1:0];
				pend_d    = issue;
				if (issue) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (pend_q) begin
					if (op_q == ght_pkg::MODE_CREATE) begin
						if (!ram_rdata.live) begin
							ram_we    = 1'b1;
							ram_wdata = '{live: 1'b1, tag: tag_q, parent: p_q};
							rs_d      = ght_pkg::ST_OK;
							rh_d      = {tag_q, pidx_ext};
							rp_d      = p_q;
							state_d   = ght_pkg::S_RESP;
						end
					end else if (ram_rdata.live && ram_rdata.parent == h_q
						&& {ram_rdata.tag, pidx_ext} != up_q) begin
						ram_we           = 1'b1;
						ram_wdata.parent = up_q;
					end
				end else if (!issue) begin
					state_d = ght_pkg::S_RESP;
					rs_d    = ght_pkg::ST_OK;
					if (op_q == ght_pkg::MODE_CREATE) begin
						if (used_q == UW'(SLOT_COUNT)) begin
							rs_d = ght_pkg::ST_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = used_q[IW-1:0];
							ram_wdata = '{live: 1'b1, tag: tag_q, parent: p_q};
							used_d    = used_q + 1'b1;
							rh_d      = {tag_q, used_ext};
							rp_d      = p_q;
						end
					end else begin
						rh_d = h_q;
						rp_d = up_q;
					end
				end
			end
			ght_pkg::S_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ght_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ght_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ght_pkg::S_IDLE;
			used_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			pend_q  <= pend_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		h_q    <= h_d;
		p_q    <= p_d;
		tag_q  <= tag_d;
		up_q   <= up_d;
		cnt_q  <= cnt_d;
		pidx_q <= pidx_d;
		rs_q   <= rs_d;
		rh_q   <= rh_d;
		rp_q   <= rp_d;
		if (out_load) begin
			out_status_q <= rs_q;
			out_handle_q <= rh_q;
			out_parent_q <= rp_q;
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(SLOT_COUNT))
		else $error("slot count beyond table size");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(used_q) |-> used_q == $past(used_q) + 1'b1)
		else $error("slot count moved by other than one");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ght_pkg::S_CHECK || state_q == ght_pkg::S_SCAN))
		else $error("slot write outside check or sweep");

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ght_pkg::S_SCAN && pend_q) |-> (UW'(pidx_q) < used_q))
		else $error("sweep read beyond slots in use");

	a_create_path: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.mode == ght_pkg::MODE_CREATE)
		|=> (state_q == ght_pkg::S_SCAN || state_q == ght_pkg::S_RESP))
		else $error("create transfer took a wrong path");

endmodule

/* sv/ght_ram.sv */
// ----------------------------------------------------------------------------
// ght_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* tb/generational_handle_table_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_handle_table_unit_tb: self-checking bench for the handle table
// Drives create, lookup, destroy and reparent requests, first a directed
// run through the special cases, then random traffic that fills the table,
// churns it and stalls the result side. A shadow copy of the slot table
// predicts every result, which is checked field by field on each transfer.
// ----------------------------------------------------------------------------
module generational_handle_table_unit_tb;

	localparam int SLOTS          = ght_pkg::SLOT_COUNT_DEF;
	localparam int HANDLE_W       = ght_pkg::HANDLE_W;
	localparam int IDX_W          = ght_pkg::IDX_W;
	localparam int TAG_W          = ght_pkg::TAG_W;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 300;

	typedef struct packed {
		ght_pkg::status_t    status;
		logic [HANDLE_W-1:0] handle_out;
		logic [HANDLE_W-1:0] parent_out;
	} slot_result_t;

	class slot_map_shadow;
		bit                  live [SLOTS];
		logic [HANDLE_W-1:0] hnd  [SLOTS];
		logic [HANDLE_W-1:0] par  [SLOTS];
		int unsigned         used;
		slot_result_t        awaited [$];
		int                  errors;

		function new();
			used = 0;
			errors = 0;
			foreach (live[i]) begin
				live[i] = 1'b0;
				hnd[i] = '0;
				par[i] = '0;
			end
		endfunction

		function ght_pkg::status_t vet_handle(logic [HANDLE_W-1:0] h,
				output int unsigned idx);
			logic [HANDLE_W-1:0] i;
			idx = 0;
			if (h == ght_pkg::NULL_HANDLE)
				return ght_pkg::ST_INVALID;
			i = {32'd0, h[IDX_W-1:0]};
			if (i >= used || i >= SLOTS)
				return ght_pkg::ST_RANGE;
			idx = h[IDX_W-1:0];
			if (h[HANDLE_W-1:IDX_W] != hnd[idx][HANDLE_W-1:IDX_W])
				return ght_pkg::ST_STALE;
			if (!live[idx])
				return ght_pkg::ST_DEAD;
			return ght_pkg::ST_OK;
		endfunction

		function void note_request(ght_pkg::mode_t m, logic [HANDLE_W-1:0] h,
				logic [HANDLE_W-1:0] p, logic [TAG_W-1:0] t);
			slot_result_t        r;
			int unsigned         idx;
			int unsigned         i;
			bit                  found;
			ght_pkg::status_t    st;
			logic [HANDLE_W-1:0] up;
			logic [HANDLE_W-1:0] gone;
			r.status = ght_pkg::ST_INVALID;
			r.handle_out = ght_pkg::NULL_HANDLE;
			r.parent_out = '0;
			idx = 0;
			found = 1'b0;
			if (m == ght_pkg::MODE_CREATE) begin
				if (t != ght_pkg::TAG_LIMIT) begin
					for (i = 0; i < used; i++) begin
						if (!live[i]) begin
							idx = i;
							found = 1'b1;
							break;
						end
					end
					if (!found && used >= SLOTS) begin
						r.status = ght_pkg::ST_FULL;
					end else begin
						if (!found) begin
							idx = used;
							used++;
						end
						live[idx] = 1'b1;
						hnd[idx] = {t, idx[IDX_W-1:0]};
						par[idx] = p;
						r = '{ght_pkg::ST_OK, hnd[idx], p};
					end
				end
			end else begin
				st = vet_handle(h, idx);
				if (st != ght_pkg::ST_OK) begin
					r.status = st;
				end else if (m == ght_pkg::MODE_DESTROY) begin
					up = par[idx];
					gone = hnd[idx];
					live[idx] = 1'b0;
					// live children move up to the grandparent, never onto themselves
					for (i = 0; i < used; i++) begin
						if (live[i] && par[i] == gone && hnd[i] != up)
							par[i] = up;
					end
					r = '{ght_pkg::ST_OK, gone, up};
				end else if (m == ght_pkg::MODE_REPARENT && p == hnd[idx]) begin
					r = '{ght_pkg::ST_SELF, hnd[idx], par[idx]};
				end else begin
					if (m == ght_pkg::MODE_REPARENT)
						par[idx] = p;
					r = '{ght_pkg::ST_OK, hnd[idx], par[idx]};
				end
			end
			awaited.insert(awaited.size(), r);
		endfunction

		task report_mismatch(string what);
			if (errors < 200)
				$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(ght_pkg::status_t s, logic [HANDLE_W-1:0] ho,
				logic [HANDLE_W-1:0] po);
			slot_result_t w;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d handle %h parent %h",
					s, ho, po));
				return;
			end
			w = awaited.pop_front();
			if (s != w.status)
				report_mismatch($sformatf("status %0d, wanted %0d", s, w.status));
			if (ho != w.handle_out)
				report_mismatch($sformatf("handle_out %h, wanted %h", ho, w.handle_out));
			if (po != w.parent_out)
				report_mismatch($sformatf("parent_out %h, wanted %h", po, w.parent_out));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ght_req_if req_ch();
	ght_rsp_if rsp_ch();

	slot_map_shadow shadow = new();

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_asked = 0;
	int quiet_cycles = 0;

	generational_handle_table_unit #(
		.SLOT_COUNT(SLOTS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			shadow.check_result(rsp_ch.status, rsp_ch.handle_out, rsp_ch.parent_out);
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL generational_handle_table_unit");
			$finish;
		end
	end

	task automatic send_op(ght_pkg::mode_t m, logic [HANDLE_W-1:0] h,
			logic [HANDLE_W-1:0] p, logic [TAG_W-1:0] t);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.handle <= h;
		req_ch.parent_handle <= p;
		req_ch.new_tag <= t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		shadow.note_request(m, h, p, t);
	endtask

	function automatic logic [HANDLE_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_target();
		int unsigned         k;
		int unsigned         idx;
		int                  tries;
		logic [HANDLE_W-1:0] h;
		k = $urandom_range(99);
		if (k < 3)
			return ght_pkg::NULL_HANDLE;
		if (k < 7 || shadow.used == 0)
			return rand64();
		// lean towards live entries so that the sequences get past the checks
		idx = $urandom_range(shadow.used - 1);
		for (tries = 0; tries < 4 && !shadow.live[idx]; tries++)
			idx = $urandom_range(shadow.used - 1);
		h = {shadow.hnd[idx][HANDLE_W-1:IDX_W], idx[IDX_W-1:0]};
		if (k < 13)
			h[HANDLE_W-1:IDX_W] = h[HANDLE_W-1:IDX_W] ^ (32'd1 << $urandom_range(31));
		else if (k < 16)
			h[IDX_W-1:0] = shadow.used + $urandom_range(3);
		return h;
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_parent(logic [HANDLE_W-1:0] h);
		int unsigned k;
		k = $urandom_range(99);
		if (k < 10)
			return h;
		if (k < 20)
			return ght_pkg::NULL_HANDLE;
		if (k < 35 || shadow.used == 0)
			return rand64();
		return shadow.hnd[$urandom_range(shadow.used - 1)];
	endfunction

	task automatic run_random(int n, int w_create, int w_lookup, int w_destroy);
		int unsigned         k;
		ght_pkg::mode_t      m;
		logic [HANDLE_W-1:0] h;
		logic [HANDLE_W-1:0] p;
		logic [TAG_W-1:0]    t;
		repeat (n) begin
			k = $urandom_range(99);
			if (k < w_create)
				m = ght_pkg::MODE_CREATE;
			else if (k < w_create + w_lookup)
				m = ght_pkg::MODE_LOOKUP;
			else if (k < w_create + w_lookup + w_destroy)
				m = ght_pkg::MODE_DESTROY;
			else
				m = ght_pkg::MODE_REPARENT;
			h = (m == ght_pkg::MODE_CREATE) ? rand64() : pick_target();
			p = pick_parent(h);
			t = ($urandom_range(99) < 4) ? ght_pkg::TAG_LIMIT : $urandom;
			// noise: every field random
			if ($urandom_range(99) < 5) begin
				m = ght_pkg::mode_t'($urandom_range(3));
				h = rand64();
				p = rand64();
				t = $urandom;
			end
			send_op(m, h, p, t);
		end
	endtask

	initial begin
		logic [HANDLE_W-1:0] ha;
		logic [HANDLE_W-1:0] hb;
		logic [HANDLE_W-1:0] hc;
		ha = {32'h0000_0000, 32'd0};
		hb = {32'hFFFF_FFFE, 32'd1};
		hc = {32'h5A5A_A5A5, 32'd2};
		req_ch.valid = 1'b0;
		req_ch.mode = ght_pkg::MODE_LOOKUP;
		req_ch.handle = '0;
		req_ch.parent_handle = '0;
		req_ch.new_tag = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 19;
		rx_idle_pct = 46;
		send_op(ght_pkg::MODE_LOOKUP, ght_pkg::NULL_HANDLE, '0, '0);
		send_op(ght_pkg::MODE_LOOKUP, 64'd0, '0, '0);
		send_op(ght_pkg::MODE_DESTROY, 64'h0123_4567_89AB_CDEF, '0, '0);
		send_op(ght_pkg::MODE_REPARENT, ght_pkg::NULL_HANDLE, 64'd0, '0);
		send_op(ght_pkg::MODE_CREATE, '0, '0, ght_pkg::TAG_LIMIT);
		send_op(ght_pkg::MODE_CREATE, '0, ght_pkg::NULL_HANDLE, ha[HANDLE_W-1:IDX_W]);
		send_op(ght_pkg::MODE_CREATE, ght_pkg::NULL_HANDLE, ha, hb[HANDLE_W-1:IDX_W]);
		send_op(ght_pkg::MODE_CREATE, '0, hb, hc[HANDLE_W-1:IDX_W]);
		send_op(ght_pkg::MODE_LOOKUP, ha, '0, '0);
		send_op(ght_pkg::MODE_LOOKUP, {32'h0000_0001, 32'd0}, '0, '0);
		send_op(ght_pkg::MODE_LOOKUP, {32'h0000_0000, 32'hFFFF_FFFF}, '0, '0);
		// parent loop between the first two entries
		send_op(ght_pkg::MODE_REPARENT, ha, hb, '0);
		send_op(ght_pkg::MODE_REPARENT, hb, hb, '0);
		send_op(ght_pkg::MODE_DESTROY, ha, '0, '0);
		send_op(ght_pkg::MODE_LOOKUP, ha, '0, '0);
		send_op(ght_pkg::MODE_DESTROY, ha, '0, '0);
		send_op(ght_pkg::MODE_LOOKUP, hb, '0, '0);
		send_op(ght_pkg::MODE_DESTROY, hb, '0, '0);
		send_op(ght_pkg::MODE_LOOKUP, hc, '0, '0);
		send_op(ght_pkg::MODE_CREATE, '0, ght_pkg::NULL_HANDLE, 32'd7);
		send_op(ght_pkg::MODE_LOOKUP, ha, '0, '0);
		send_op(ght_pkg::MODE_REPARENT, hc, 64'hFFFF_FFFF_FFFF_FFFE, '0);
		send_op(ght_pkg::MODE_DESTROY, hc ^ 64'h8000_0000_0000_0000, '0, '0);
		send_op(ght_pkg::MODE_CREATE, ght_pkg::NULL_HANDLE, '0, 32'hFFFF_FFFE);

		// fill the table up to full and beyond
		run_random(340, 85, 6, 3);

		tx_idle_pct = 46;
		rx_idle_pct = 19;
		run_random(250, 30, 25, 25);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_asked++;
		run_random(160, 35, 25, 20);
		req_ch.valid <= 1'b0;

		while (shadow.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("PASS generational_handle_table_unit");
		else
			$display("FAIL generational_handle_table_unit");
		$finish;
	end

endmodule

/* files.f */
sv/ght_pkg.sv
sv/ght_req_if.sv
sv/ght_rsp_if.sv
sv/ght_ram.sv
sv/generational_handle_table_unit.sv
tb/generational_handle_table_unit_tb.sv
